// ===== hdl/binary_heap_priority_queue_macros.svh =====
// ============================================================================
// Assertion macros for the binary heap priority queue
// Shared shorthand for clocked implication checks with a synchronous reset.
// ============================================================================
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bhpq_pkg.sv =====
// ============================================================================
// bhpq_pkg
// Types and constants shared by the heap controller, datapath and top level.
// ============================================================================
package bhpq_pkg;

   // Default sizing of the heap storage.
   localparam int DEF_CAPACITY   = 1024;
   localparam int DEF_DATA_WIDTH = 32;

   // Fixed port widths.
   localparam int VALUE_W  = 32;
   localparam int TOP_W    = 32;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // Request action codes.
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_PUSH_START,
      OP_POP_START,
      OP_POP_LOAD,
      OP_UP_READ,
      OP_UP_EVAL,
      OP_DN_READ,
      OP_DN_EVAL,
      OP_PLACE
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type op;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic has_left;
      logic up_move;
      logic dn_move;
   } dp_status_type;

endpackage

// ===== hdl/bhpq_ram.sv =====
// ============================================================================
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a_ff,
   output logic [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

// ===== hdl/bhpq_datapath.sv =====
// ============================================================================
// bhpq_datapath
// Heap storage, element count, hole index and moving element, with the
// comparators used by sift-up and sift-down.
// ============================================================================
`include "binary_heap_priority_queue_macros.svh"

module bhpq_datapath #(
   parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bhpq_pkg::cmd_type                   cmd,
   input  logic signed [bhpq_pkg::VALUE_W-1:0] req_value,
   input  logic                                csr_we,
   input  logic                                csr_wdata,
   output bhpq_pkg::dp_status_type             status,
   output logic signed [bhpq_pkg::TOP_W-1:0]   rsp_top,
   output logic [bhpq_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                hole_ff, hole_in;
   logic signed [DATA_WIDTH-1:0] mover_ff, mover_in;
   logic signed [DATA_WIDTH-1:0] root_ff, root_in;
   logic                         max_order_ff;

   logic [CW-1:0]                parent_idx;
   logic [CW-1:0]                last_idx;
   logic [CW:0]                  left_idx, right_idx, count_ext;
   logic                         has_left, has_right;
   logic                         left_win, right_win;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_WIDTH-1:0]        wr_data, rd_a_raw, rd_b_raw;
   logic signed [DATA_WIDTH-1:0] rd_a, rd_b;

   // True when a belongs strictly closer to the root than b.
   function automatic logic outranks(input logic signed [DATA_WIDTH-1:0] a,
                                     input logic signed [DATA_WIDTH-1:0] b,
                                     input logic max_o);
      return max_o ? (a > b) : (a < b);
   endfunction

   bhpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_a_ff (rd_a_raw),
      .rd_data_b_ff (rd_b_raw)
   );

   assign rd_a = $signed(rd_a_raw);
   assign rd_b = $signed(rd_b_raw);

   // Tree indexes around the hole.
   assign parent_idx = (hole_ff - CW'(1)) >> 1;
   assign last_idx   = count_ff - CW'(1);
   assign left_idx   = {hole_ff, 1'b1};
   assign right_idx  = {hole_ff, 1'b0} + (CW + 1)'(2);
   assign count_ext  = {1'b0, count_ff};
   assign has_left   = left_idx < count_ext;
   assign has_right  = right_idx < count_ext;

   // Child selection; on a tie between children the left child wins, and on a tie with the mover the hole stays put.
   assign right_win = has_right && outranks(rd_b, rd_a, max_order_ff)
                      && outranks(rd_b, mover_ff, max_order_ff);
   assign left_win  = has_left && outranks(rd_a, mover_ff, max_order_ff);

   // Status back to the controller.
   assign status.full     = count_ff == CW'(CAPACITY);
   assign status.empty    = count_ff == '0;
   assign status.at_root  = hole_ff == '0;
   assign status.has_left = has_left;
   assign status.up_move  = outranks(mover_ff, rd_a, max_order_ff);
   assign status.dn_move  = right_win || left_win;

   // Operation decode: addresses, write and next values.
   always_comb begin
      count_in  = count_ff;
      hole_in   = hole_ff;
      mover_in  = mover_ff;
      wr_en     = 1'b0;
      wr_addr   = hole_ff[AW-1:0];
      wr_data   = mover_ff;
      rd_addr_a = parent_idx[AW-1:0];
      rd_addr_b = right_idx[AW-1:0];
      unique case (cmd.op)
         bhpq_pkg::OP_IDLE: begin
         end
         bhpq_pkg::OP_PUSH_START: begin
            mover_in = DATA_WIDTH'(req_value);
            hole_in  = count_ff;
            count_in = count_ff + CW'(1);
         end
         bhpq_pkg::OP_POP_START: begin
            count_in  = last_idx;
            hole_in   = '0;
            rd_addr_a = last_idx[AW-1:0];
         end
         bhpq_pkg::OP_POP_LOAD: begin
            mover_in = rd_a;
         end
         bhpq_pkg::OP_UP_READ: begin
            rd_addr_a = parent_idx[AW-1:0];
         end
         bhpq_pkg::OP_UP_EVAL: begin
            wr_en = 1'b1;
            if (status.up_move) begin
               wr_data = rd_a;
               hole_in = parent_idx;
            end
         end
         bhpq_pkg::OP_DN_READ: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
         end
         bhpq_pkg::OP_DN_EVAL: begin
            wr_en = 1'b1;
            priority if (right_win) begin
               wr_data = rd_b;
               hole_in = right_idx[CW-1:0];
            end else if (left_win) begin
               wr_data = rd_a;
               hole_in = left_idx[CW-1:0];
            end
         end
         bhpq_pkg::OP_PLACE: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The root is mirrored in a register so the result needs no extra read.
   assign root_in = (wr_en && wr_addr == '0) ? wr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_order_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            max_order_ff <= csr_wdata;
         end
      end
      hole_ff  <= hole_in;
      mover_ff <= mover_in;
      root_ff  <= root_in;
   end

   // Result word fields.
   assign rsp_top   = status.empty ? '1 : bhpq_pkg::TOP_W'(root_ff);
   assign rsp_count = bhpq_pkg::COUNT_W'(count_ff);

   `BHPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "heap count exceeds capacity")
   `BHPQ_ASSERT_SAME(a_right_needs_left, clock, reset, has_right, has_left, "right child without left child")
   `BHPQ_ASSERT_NEXT(a_root_mirror, clock, reset, wr_en && wr_addr == '0, root_ff == $past(wr_data), "root register missed a write to slot zero")

endmodule

// ===== hdl/bhpq_ctrl.sv =====
// ============================================================================
// bhpq_ctrl
// Sequencer for push and pop: walks the hole up or down the heap one level
// per read/evaluate pair and issues the result word.
// ============================================================================
`include "binary_heap_priority_queue_macros.svh"

module bhpq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 req_action,
   input  bhpq_pkg::dp_status_type              status,
   output bhpq_pkg::cmd_type                    cmd,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic [bhpq_pkg::STATUS_W-1:0]        rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_LOAD,
      ST_UP_READ,
      ST_UP_EVAL,
      ST_DN_READ,
      ST_DN_EVAL,
      ST_REPORT
   } state_type;

   state_type            state_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   bhpq_pkg::status_type status_ff;
   logic                 accept;

   assign accept = start && !busy_ff;

   // Datapath operation for the current state.
   always_comb begin
      cmd.op = bhpq_pkg::OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == bhpq_pkg::ACT_PUSH) begin
                  cmd.op = status.full ? bhpq_pkg::OP_IDLE : bhpq_pkg::OP_PUSH_START;
               end else begin
                  cmd.op = status.empty ? bhpq_pkg::OP_IDLE : bhpq_pkg::OP_POP_START;
               end
            end
         end
         ST_POP_LOAD: cmd.op = bhpq_pkg::OP_POP_LOAD;
         ST_UP_READ:  cmd.op = status.at_root ? bhpq_pkg::OP_PLACE : bhpq_pkg::OP_UP_READ;
         ST_UP_EVAL:  cmd.op = bhpq_pkg::OP_UP_EVAL;
         ST_DN_READ:  cmd.op = status.has_left ? bhpq_pkg::OP_DN_READ : bhpq_pkg::OP_PLACE;
         ST_DN_EVAL:  cmd.op = bhpq_pkg::OP_DN_EVAL;
         ST_REPORT:   cmd.op = bhpq_pkg::OP_IDLE;
         default:     cmd.op = bhpq_pkg::OP_IDLE;
      endcase
   end

   // State, busy flag and the registered result strobe and status.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= bhpq_pkg::STATUS_OK;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  busy_ff <= 1'b1;
                  if (req_action == bhpq_pkg::ACT_PUSH) begin
                     if (status.full) begin
                        status_ff    <= bhpq_pkg::STATUS_FULL;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_REPORT;
                     end else begin
                        status_ff <= bhpq_pkg::STATUS_OK;
                        state_ff  <= ST_UP_READ;
                     end
                  end else begin
                     if (status.empty) begin
                        status_ff    <= bhpq_pkg::STATUS_EMPTY;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_REPORT;
                     end else begin
                        status_ff <= bhpq_pkg::STATUS_OK;
                        state_ff  <= ST_POP_LOAD;
                     end
                  end
               end
            end
            ST_POP_LOAD: begin
               if (status.empty) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_REPORT;
               end else begin
                  state_ff <= ST_DN_READ;
               end
            end
            ST_UP_READ: begin
               if (status.at_root) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_REPORT;
               end else begin
                  state_ff <= ST_UP_EVAL;
               end
            end
            ST_UP_EVAL: begin
               if (status.up_move) begin
                  state_ff <= ST_UP_READ;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_REPORT;
               end
            end
            ST_DN_READ: begin
               if (status.has_left) begin
                  state_ff <= ST_DN_EVAL;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_REPORT;
               end
            end
            ST_DN_EVAL: begin
               if (status.dn_move) begin
                  state_ff <= ST_DN_READ;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_REPORT;
               end
            end
            ST_REPORT: begin
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

   `BHPQ_ASSERT_SAME(a_strobe_while_busy, clock, reset, rsp_valid_ff, busy_ff, "result word outside an operation")
   `BHPQ_ASSERT_NEXT(a_accept_sets_busy, clock, reset, accept, busy_ff, "busy not raised after accept")
   `BHPQ_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff && !busy_ff, "result word not single or busy not released")

endmodule

// ===== hdl/binary_heap_priority_queue.sv =====
// ============================================================================
// binary_heap_priority_queue
// Array binary heap priority queue with selectable max or min order.
// ============================================================================
//
//  Channel   Ports                                       Handshake
//  --------  ------------------------------------------  -------------------
//  request   req_action, req_value                       start high, busy low
//  result    rsp_top, rsp_count, rsp_status              rsp_valid, 1 cycle
//  config    csr_wdata (max_order)                       csr_we
//
//  A push climbs the new word toward the root until it no longer outranks its
//  parent; a pop moves the last word to the root and sinks it until no child
//  outranks it, and a pop that empties the heap ends without sinking. A push
//  while full is dropped and a pop while empty is ignored. Each level is one
//  RAM read then a compare and write; the result word cannot be stalled.
//  Reset is synchronous and empties the heap; max order is set.
//
module binary_heap_priority_queue #(
   parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic signed [bhpq_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic signed [bhpq_pkg::TOP_W-1:0]    rsp_top,
   output logic [bhpq_pkg::COUNT_W-1:0]         rsp_count,
   output logic [bhpq_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                 csr_we,
   input  logic                                 csr_wdata
);

   bhpq_pkg::cmd_type       cmd;
   bhpq_pkg::dp_status_type dp_status;

   // Sequencer.
   bhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (dp_status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   // Storage and compare logic.
   bhpq_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_value),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (dp_status),
      .rsp_top   (rsp_top),
      .rsp_count (rsp_count)
   );

endmodule
